// File: rtl/core/hpack_dynamic_table_allocator_core_defines.svh
// assertion macros shared by the allocator rtl
`ifndef HPACK_DYNAMIC_TABLE_ALLOCATOR_CORE_DEFINES_SVH
`define HPACK_DYNAMIC_TABLE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HPDTA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, sampled on clk, off during rst
`define HPDTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: rtl/core/hpdta_pkg.sv
// shared constants and types for the hpack dynamic table allocator
package hpdta_pkg;
  localparam int LEN_W         = 10;
  localparam int ADDR_W        = 10;
  localparam int EV_W          = 6;
  localparam int SIZE_W        = 11;
  localparam int CALC_W        = 14;
  localparam int MAX_TABLE     = 1024;
  localparam int RFC_OVERHEAD  = 32;
  localparam int HEADER_BYTES  = 32;
  localparam int SLOT_BYTES    = 8;
  localparam int DEF_MAX_ENTRIES = 32;

  localparam logic KIND_INSERT    = 1'b0;
  localparam logic KIND_MOVE      = 1'b1;
  localparam logic STATUS_STORED  = 1'b0;
  localparam logic STATUS_FLUSHED = 1'b1;

  typedef logic [SIZE_W-1:0] bytes_t;

  typedef struct packed {
    bytes_t addr;
    bytes_t len;
  } entry_t;
endpackage

// File: rtl/core/hpdta_if.sv
// valid/ready channels for insert requests and allocator results
interface hpdta_req_if;
  import hpdta_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  name_length;
  logic [LEN_W-1:0]  value_length;
  modport source (output valid, output name_length, output value_length, input ready);
  modport sink   (input valid, input name_length, input value_length, output ready);
endinterface

interface hpdta_res_if;
  import hpdta_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              status;
  logic [ADDR_W-1:0] dest_address;
  logic [ADDR_W-1:0] src_address;
  logic [LEN_W-1:0]  move_length;
  logic [EV_W-1:0]   evicted_count;
  logic              last;
  modport source (output valid, output kind, output status, output dest_address,
                  output src_address, output move_length, output evicted_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input status, input dest_address,
                  input src_address, input move_length, input evicted_count,
                  input last, output ready);
endinterface

// File: rtl/core/hpdta_mem.sv
// entry store: one write port, one registered read port
module hpdta_mem #(
  parameter int AW = 6,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/hpack_dynamic_table_allocator_core.sv
// An insert may evict the oldest entries, and may run an index compaction or a space compaction,
// before its final beat; an oversized entry flushes the table. Output stalls can hold any beat.
// One insert is handled at a time; the next is accepted in the cycle after the final beat loads.
// Reset: rst is synchronous active high; it empties the table and sets table_size to 1024.
`include "hpack_dynamic_table_allocator_core_defines.svh"

module hpack_dynamic_table_allocator_core #(
  parameter int MAX_ENTRIES = hpdta_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hpdta_pkg::SIZE_W-1:0] cfg_wdata,
  hpdta_req_if.sink                 req,
  hpdta_res_if.source               res
);
  import hpdta_pkg::*;

  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 2);
  localparam int TW = CW + 2;
  localparam int MW = SW + 1;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_EV_RD    = 5'd2;
  localparam logic [4:0] S_EV_UPD   = 5'd3;
  localparam logic [4:0] S_EMPTY    = 5'd4;
  localparam logic [4:0] S_PREP2    = 5'd5;
  localparam logic [4:0] S_CMP_INIT = 5'd6;
  localparam logic [4:0] S_CMP_RD   = 5'd7;
  localparam logic [4:0] S_CMP_USE  = 5'd8;
  localparam logic [4:0] S_CMP_DONE = 5'd9;
  localparam logic [4:0] S_POSTA    = 5'd10;
  localparam logic [4:0] S_RD_A     = 5'd11;
  localparam logic [4:0] S_RD_B     = 5'd12;
  localparam logic [4:0] S_RD_C     = 5'd13;
  localparam logic [4:0] S_DECIDE   = 5'd14;
  localparam logic [4:0] S_POSTB    = 5'd15;
  localparam logic [4:0] S_BCHK     = 5'd16;
  localparam logic [4:0] S_COMMIT   = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;

  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  // slot index of a count, zero when past the index
  function automatic logic [SW-1:0] slf(input logic [CW-1:0] x);
    return (x < MAXC) ? x[SW-1:0] : '0;
  endfunction

  // slot of the oldest entry
  function automatic logic [CW-1:0] tail_fn(input logic [SW-1:0] hd,
                                            input logic [CW-1:0] u,
                                            input logic [CW-1:0] w);
    logic signed [TW-1:0] t;
    t = $signed(TW'(hd)) + $signed(TW'(1)) - $signed(TW'(u));
    if ((TW'(hd) + TW'(1)) < TW'(u)) begin
      t = t + $signed(TW'(w));
    end
    return (t < 0) ? '0 : t[CW-1:0];
  endfunction

  // size rule violated or index full
  function automatic logic over_fn(input logic [CW-1:0] u, input bytes_t tot,
                                   input bytes_t nd, input bytes_t sz);
    logic [CALC_W-1:0] s;
    s = (CALC_W'(u) << 5) + CALC_W'(tot) + CALC_W'(nd) + CALC_W'(RFC_OVERHEAD);
    return (s > CALC_W'(sz)) || (u >= MAXC);
  endfunction

  // end of the index for a given slot count
  function automatic logic signed [CALC_W-1:0] hdr_end(input logic [CW-1:0] w);
    return $signed(CALC_W'(HEADER_BYTES) + CALC_W'(w) * CALC_W'(SLOT_BYTES));
  endfunction

  function automatic logic signed [CALC_W-1:0] sx(input bytes_t x);
    return $signed(CALC_W'(x));
  endfunction

  logic [4:0]      state;
  bytes_t          table_size;
  bytes_t          sz;
  bytes_t          need;
  logic [EV_W-1:0] ev;
  logic            bank;
  logic            cmode_b;
  logic [SW-1:0]   head, front, prev, tl, t_slot;
  logic [CW-1:0]   used, wrap, u_cnt, w_cnt, h, old, k;
  bytes_t          total, acc, fa, ta, tlen, fin_addr;
  logic            fin_status;

  logic            mem_we, mem_re;
  logic [MW-1:0]   mem_wa, mem_ra;
  entry_t          mem_wd, mem_rd;
  logic [SW-1:0]   rd_slot;
  logic            out_free;

  hpdta_mem #(.AW(MW), .DW($bits(entry_t))) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !res.valid || res.ready;

  // read address per sequencer step
  always_comb begin
    mem_re  = 1'b1;
    rd_slot = front;
    unique case (state)
      S_EV_RD:  rd_slot = slf(tail_fn(head, u_cnt, w_cnt));
      S_CMP_RD: rd_slot = slf(old);
      S_RD_B:   rd_slot = tl;
      S_RD_C:   rd_slot = prev;
      S_EMPTY, S_RD_A, S_POSTB: rd_slot = front;
      default:  mem_re = 1'b0;
    endcase
    mem_ra = {bank, rd_slot};
  end

  // compaction step values
  bytes_t cmp_a;
  logic   cmp_move;
  assign cmp_a    = (acc > mem_rd.len) ? (acc - mem_rd.len) : '0;
  assign cmp_move = (mem_rd.addr != cmp_a);

  // a result beat is loaded this cycle
  logic   res_load;
  assign res_load = out_free && ((state == S_CMP_USE && cmp_move) || state == S_FIN);

  // eviction step values
  bytes_t        ev_tot;
  logic [CW-1:0] ev_u;
  assign ev_tot = (total > mem_rd.len) ? (total - mem_rd.len) : '0;
  assign ev_u   = u_cnt - CW'(1);

  // room next to the newest entry
  logic signed [CALC_W-1:0] hr, tr, hr_raw, tr_raw, cand;
  logic                     same;
  always_comb begin
    same   = (prev == front);
    hr_raw = same ? (sx(fa) - hdr_end(w_cnt)) : '0;
    tr_raw = same ? (sx(sz) - sx(ta) - sx(tlen))
                  : (sx(mem_rd.addr) - sx(ta) - sx(tlen));
    hr     = (hr_raw < 0) ? '0 : hr_raw;
    tr     = (tr_raw < 0) ? '0 : tr_raw;
    cand   = sx(mem_rd.addr) - sx(need);
  end

  // entry store writes
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {bank, h[SW-1:0]};
    mem_wd = '{addr: fin_addr, len: need};
    if (state == S_CMP_USE && (!cmp_move || out_free)) begin
      mem_we = 1'b1;
      mem_wa = {~bank, k[SW-1:0]};
      mem_wd = '{addr: cmp_a, len: mem_rd.len};
    end else if (state == S_COMMIT) begin
      mem_we = 1'b1;
    end else if (state == S_EMPTY && used == '0
                 && (sx(sz) - sx(need)) >= $signed(CALC_W'(HEADER_BYTES + SLOT_BYTES))) begin
      mem_we = 1'b1;
      mem_wa = {bank, {SW{1'b0}}};
      mem_wd = '{addr: sz - need, len: need};
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(MAX_TABLE);
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      front     <= '0;
      used      <= '0;
      wrap      <= '0;
      total     <= '0;
      bank      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !res_load) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            need  <= SIZE_W'(req.name_length) + SIZE_W'(req.value_length);
            sz    <= (table_size > SIZE_W'(MAX_TABLE)) ? SIZE_W'(MAX_TABLE) : table_size;
            ev    <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((CALC_W'(need) + CALC_W'(RFC_OVERHEAD)) > CALC_W'(sz)) begin
            ev         <= EV_W'(used);
            used       <= '0; total <= '0; head <= '0; front <= '0; wrap <= '0;
            fin_status <= STATUS_FLUSHED;
            state      <= S_FIN;
          end else if (used != '0 && over_fn(used, total, need, sz)) begin
            u_cnt <= used;
            w_cnt <= wrap;
            state <= S_EV_RD;
          end else begin
            state <= S_EMPTY;
          end
        end
        S_EV_RD: begin
          t_slot <= slf(tail_fn(head, u_cnt, w_cnt));
          state  <= S_EV_UPD;
        end
        S_EV_UPD: begin
          total <= ev_tot;
          ev    <= ev + EV_W'(1);
          if (t_slot == front) begin
            front <= head;
          end
          if (ev_u != '0 && over_fn(ev_u, ev_tot, need, sz)) begin
            u_cnt <= ev_u;
            state <= S_EV_RD;
          end else begin
            used <= ev_u;
            if (ev_u == '0) begin
              front <= '0;
              head  <= '0;
              wrap  <= CW'(1);
            end else if ((CW'(head) + CW'(1)) >= ev_u) begin
              wrap <= CW'(head) + CW'(1);
            end
            state <= S_EMPTY;
          end
        end
        S_EMPTY: begin
          if (used == '0) begin
            if ((sx(sz) - sx(need)) < $signed(CALC_W'(HEADER_BYTES + SLOT_BYTES))) begin
              used <= '0; total <= '0; head <= '0; front <= '0; wrap <= '0;
              fin_status <= STATUS_FLUSHED;
            end else begin
              head       <= '0;
              front      <= '0;
              wrap       <= CW'(1);
              used       <= CW'(1);
              total      <= need;
              fin_addr   <= sz - need;
              fin_status <= STATUS_STORED;
            end
            state <= S_FIN;
          end else begin
            prev  <= head;
            w_cnt <= wrap;
            tl    <= slf(tail_fn(head, used, wrap));
            u_cnt <= used + CW'(1);
            h     <= CW'(head) + CW'(1);
            state <= S_PREP2;
          end
        end
        S_PREP2: begin
          if (h >= w_cnt) begin
            if (hdr_end(w_cnt + CW'(1)) <= sx(mem_rd.addr)
                && (w_cnt + CW'(1)) <= MAXC) begin
              w_cnt <= w_cnt + CW'(1);
              state <= S_RD_A;
            end else if (h >= u_cnt) begin
              h     <= '0;
              state <= S_RD_A;
            end else begin
              cmode_b <= 1'b0;
              state   <= S_CMP_INIT;
            end
          end else if (u_cnt >= w_cnt) begin
            cmode_b <= 1'b0;
            state   <= S_CMP_INIT;
          end else begin
            state <= S_RD_A;
          end
        end
        S_CMP_INIT: begin
          old   <= tail_fn(head, used, wrap);
          acc   <= sz;
          k     <= '0;
          state <= S_CMP_RD;
        end
        S_CMP_RD: begin
          state <= S_CMP_USE;
        end
        S_CMP_USE: begin
          if (!cmp_move || out_free) begin
            if (cmp_move) begin
              res.valid         <= 1'b1;
              res.kind          <= KIND_MOVE;
              res.status        <= STATUS_STORED;
              res.dest_address  <= cmp_a[ADDR_W-1:0];
              res.src_address   <= mem_rd.addr[ADDR_W-1:0];
              res.move_length   <= mem_rd.len[LEN_W-1:0];
              res.evicted_count <= '0;
              res.last          <= 1'b0;
            end
            acc   <= cmp_a;
            old   <= ((old + CW'(1)) >= wrap) ? '0 : (old + CW'(1));
            k     <= k + CW'(1);
            state <= ((k + CW'(1)) == used) ? S_CMP_DONE : S_CMP_RD;
          end
        end
        S_CMP_DONE: begin
          bank  <= ~bank;
          wrap  <= used;
          head  <= SW'(used - CW'(1));
          front <= SW'(used - CW'(1));
          state <= cmode_b ? S_POSTB : S_POSTA;
        end
        S_POSTA: begin
          w_cnt <= wrap + CW'(1);
          h     <= CW'(head) + CW'(1);
          prev  <= head;
          tl    <= '0;
          state <= S_RD_A;
        end
        S_RD_A: begin
          h     <= (h < MAXC) ? h : '0;
          state <= S_RD_B;
        end
        S_RD_B: begin
          fa    <= mem_rd.addr;
          state <= S_RD_C;
        end
        S_RD_C: begin
          ta    <= mem_rd.addr;
          tlen  <= mem_rd.len;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (same && hr >= sx(need)) begin
            fin_addr <= fa - need;
            front    <= h[SW-1:0];
            state    <= S_COMMIT;
          end else if (tr >= sx(need)) begin
            fin_addr <= SIZE_W'(sx(ta) + sx(tlen) + tr - sx(need));
            state    <= S_COMMIT;
          end else begin
            cmode_b <= 1'b1;
            state   <= S_CMP_INIT;
          end
        end
        S_POSTB: begin
          w_cnt <= wrap + CW'(1);
          h     <= CW'(slf(CW'(head) + CW'(1)));
          state <= S_BCHK;
        end
        S_BCHK: begin
          if (w_cnt > MAXC || cand < hdr_end(w_cnt)) begin
            ev         <= ev + EV_W'(used);
            used       <= '0; total <= '0; head <= '0; front <= '0; wrap <= '0;
            fin_status <= STATUS_FLUSHED;
            state      <= S_FIN;
          end else begin
            fin_addr <= SIZE_W'(cand);
            front    <= h[SW-1:0];
            state    <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          wrap       <= w_cnt;
          head       <= h[SW-1:0];
          used       <= u_cnt;
          total      <= total + need;
          fin_status <= STATUS_STORED;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            res.valid         <= 1'b1;
            res.kind          <= KIND_INSERT;
            res.status        <= fin_status;
            res.dest_address  <= (fin_status == STATUS_FLUSHED) ? '0 : fin_addr[ADDR_W-1:0];
            res.src_address   <= '0;
            res.move_length   <= '0;
            res.evicted_count <= ev;
            res.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `HPDTA_ASSERT_NOW(a_flush_dest, res.valid && res.last && res.status, res.dest_address == '0)
  `HPDTA_ASSERT_NOW(a_move_shape, res.valid && res.kind == KIND_MOVE, !res.last && res.evicted_count == '0)
  `HPDTA_ASSERT_NOW(a_used_bound, 1'b1, used <= MAXC)
  `HPDTA_ASSERT_NEXT(a_busy_after, req.valid && req.ready, !req.ready)
  `HPDTA_ASSERT_NOW(a_cmp_walk, state == S_CMP_USE, k < used)
endmodule
